>>> sv/lmn_pkg.sv
// Shared types and constants for the Lamport mutual exclusion node.
// No dependencies; imported by lmn_unit and lamport_mutex_node.
`timescale 1ns / 1ps

package lmn_pkg;

    localparam int CLOCK_BITS  = 15;
    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 4;
    localparam int CNT_W       = 4;

    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = {CLOCK_BITS{1'b1}};
    localparam logic [CNT_W-1:0]      CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [1:0] CMD_LREQ = 2'd0;
    localparam logic [1:0] CMD_LREL = 2'd1;
    localparam logic [1:0] CMD_MSG  = 2'd2;

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_BCAST = 3'd1;
    localparam logic [2:0] ACT_REPLY = 3'd2;
    localparam logic [2:0] ACT_GRANT = 3'd3;
    localparam logic [2:0] ACT_FULL  = 3'd4;

    localparam logic CFG_OWN_ID     = 1'b0;
    localparam logic CFG_PROC_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_LESS    = 2'd0,
        OP_TICK    = 2'd1,
        OP_MAXTICK = 2'd2
    } op_t;

    typedef struct packed {
        logic [CLOCK_BITS-1:0] time_val;
        logic [ID_W-1:0]       id;
    } key_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  msg_kind;
        logic [14:0] msg_time;
        logic [14:0] remote_time;
        logic [3:0]  req_id;
    } in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  dest_id;
        logic [14:0] stamp;
        logic [3:0]  done_count;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [ID_W-1:0]       dest_id;
        logic [CLOCK_BITS-1:0] stamp;
    } pend_t;

endpackage

>>> sv/lmn_unit.sv
// Shared compare and clock-advance unit of the mutual exclusion node.
// Depends on lmn_pkg (key_t, op_t, CLOCK_MAX).
`timescale 1ns / 1ps

module lmn_unit
    import lmn_pkg::*;
(
    input  op_t                   op,
    input  key_t                  a,
    input  key_t                  b,
    output logic                  less,
    output logic [CLOCK_BITS-1:0] value
);

    logic [CLOCK_BITS-1:0] base;

    always_comb
    begin
        less = (a.time_val < b.time_val) ||
               ((a.time_val == b.time_val) && (a.id < b.id));
        base = a.time_val;
        if ((op == OP_MAXTICK) && (b.time_val > a.time_val))
        begin
            base = b.time_val;
        end
        value = (base == CLOCK_MAX) ? CLOCK_MAX : base + 1'b1;
    end

endmodule

>>> sv/lamport_mutex_node.sv
// Top level of one Lamport-clock mutual exclusion node with its sorted request queue.
// Depends on lmn_pkg and lmn_unit.
`timescale 1ns / 1ps

// One item at a time: the node takes a command beat, works it through a small
// sequencer around a single compare/clock-advance unit and a one-port-read queue
// memory, then sends one or more result beats, the final one marked with last.
// A sorted insertion does more work for each entry it moves toward the tail, a release
// sends one reply beat per other queued entry, and result stalls hold the sequencer.
// The result register lets the next command beat in while the last result waits.
module lamport_mutex_node
    import lmn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  in_t  item,
    output logic result_valid,
    input  logic result_ready,
    output out_t result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [ID_W-1:0] cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_MSG      = 12'b0000_0000_0010,
        S_REPLY    = 12'b0000_0000_0100,
        S_RCMP     = 12'b0000_0000_1000,
        S_RNOW     = 12'b0000_0001_0000,
        S_LREQ     = 12'b0000_0010_0000,
        S_INS      = 12'b0000_0100_0000,
        S_WALK     = 12'b0000_1000_0000,
        S_PUT      = 12'b0001_0000_0000,
        S_REL_READ = 12'b0010_0000_0000,
        S_REL_EMIT = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    in_t                   item_reg, item_next;
    logic [ID_W-1:0]       own_id_reg, own_id_next;
    logic [ID_W-1:0]       proc_cnt_reg, proc_cnt_next;
    logic [CLOCK_BITS-1:0] clock_reg, clock_next;
    logic                  requested_reg, requested_next;
    logic [CLOCK_BITS-1:0] own_time_reg, own_time_next;
    logic [CNT_W-1:0]      reply_cnt_reg, reply_cnt_next;
    logic [CNT_W-1:0]      done_reg, done_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [QIDX_W-1:0]     idx_reg, idx_next;
    key_t                  key_reg, key_next;
    pend_t                 pend_reg, pend_next;
    logic                  result_valid_reg, result_valid_next;
    out_t                  result_reg, result_next;

    key_t                  mem [QUEUE_DEPTH];
    key_t                  rd_data_reg;
    logic                  mem_we, mem_re;
    logic [QIDX_W-1:0]     mem_waddr, mem_raddr;
    key_t                  mem_wdata;

    op_t                   u_op;
    key_t                  u_a, u_b;
    logic                  u_less;
    logic [CLOCK_BITS-1:0] u_value;

    logic                  out_free;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  rel_last;
    pend_t                 pend_none;

    lmn_unit u_unit (
        .op    (u_op),
        .a     (u_a),
        .b     (u_b),
        .less  (u_less),
        .value (u_value)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;
    assign cnt_inc      = (reply_cnt_reg == CNT_MAX) ? CNT_MAX : reply_cnt_reg + 1'b1;
    assign rel_last     = (LEN_W'(idx_reg) + 1'b1) == len_reg;
    assign pend_none    = '{action: ACT_NONE, dest_id: '0, stamp: '0};

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        own_id_next       = own_id_reg;
        proc_cnt_next     = proc_cnt_reg;
        clock_next        = clock_reg;
        requested_next    = requested_reg;
        own_time_next     = own_time_reg;
        reply_cnt_next    = reply_cnt_reg;
        done_next         = done_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        key_next          = key_reg;
        pend_next         = pend_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = key_reg;
        mem_re            = 1'b0;
        mem_raddr         = '0;
        u_op              = OP_TICK;
        u_a               = '{time_val: clock_reg, id: '0};
        u_b               = '{time_val: '0, id: '0};

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_ID:     own_id_next   = cfg_data;
                CFG_PROC_COUNT: proc_cnt_next = cfg_data;
                default:        own_id_next   = own_id_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    pend_next  = pend_none;
                    state_next = S_EMIT;
                    case (item.cmd)
                        CMD_MSG:
                        begin
                            state_next = S_MSG;
                        end
                        CMD_LREQ:
                        begin
                            if (!requested_reg)
                            begin
                                if (len_reg == LEN_W'(QUEUE_DEPTH))
                                begin
                                    pend_next.action = ACT_FULL;
                                end
                                else
                                begin
                                    state_next = S_LREQ;
                                end
                            end
                        end
                        CMD_LREL:
                        begin
                            if (requested_reg)
                            begin
                                requested_next = 1'b0;
                                if (len_reg <= LEN_W'(1))
                                begin
                                    len_next = '0;
                                end
                                else
                                begin
                                    idx_next   = QIDX_W'(1);
                                    state_next = S_REL_READ;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_MSG:
            begin
                u_op       = OP_MAXTICK;
                u_b        = '{time_val: item_reg.msg_time, id: '0};
                clock_next = u_value;
                state_next = S_EMIT;
                case (item_reg.msg_kind)
                    KIND_REQ:
                    begin
                        state_next = S_RCMP;
                    end
                    KIND_REPLY:
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_REPLY;
                    end
                    KIND_DONE:
                    begin
                        done_next = (done_reg == CNT_MAX) ? CNT_MAX : done_reg + 1'b1;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_REPLY:
            begin
                if ((proc_cnt_reg != '0) && (cnt_inc == proc_cnt_reg - 1'b1) &&
                    (len_reg != '0) && (rd_data_reg.id == own_id_reg))
                begin
                    reply_cnt_next   = '0;
                    pend_next.action = ACT_GRANT;
                end
                else
                begin
                    reply_cnt_next = cnt_inc;
                end
                state_next = S_EMIT;
            end
            S_RCMP:
            begin
                u_op = OP_LESS;
                u_a  = '{time_val: item_reg.remote_time, id: item_reg.req_id};
                u_b  = '{time_val: own_time_reg, id: own_id_reg};
                if (!requested_reg || u_less)
                begin
                    state_next = S_RNOW;
                end
                else if (len_reg == LEN_W'(QUEUE_DEPTH))
                begin
                    pend_next.action = ACT_FULL;
                    state_next       = S_EMIT;
                end
                else
                begin
                    key_next   = '{time_val: item_reg.remote_time, id: item_reg.req_id};
                    state_next = S_INS;
                end
            end
            S_RNOW:
            begin
                clock_next = u_value;
                pend_next  = '{action: ACT_REPLY, dest_id: item_reg.req_id, stamp: u_value};
                state_next = S_EMIT;
            end
            S_LREQ:
            begin
                clock_next     = u_value;
                own_time_next  = u_value;
                requested_next = 1'b1;
                key_next       = '{time_val: u_value, id: own_id_reg};
                pend_next      = '{action: ACT_BCAST, dest_id: '0, stamp: u_value};
                state_next     = S_INS;
            end
            S_INS:
            begin
                if (len_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    len_next   = len_reg + 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = QIDX_W'(len_reg - 1'b1);
                    idx_next   = QIDX_W'(len_reg - 1'b1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                u_op      = OP_LESS;
                u_a       = key_reg;
                u_b       = rd_data_reg;
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 1'b1;
                if (u_less)
                begin
                    mem_wdata = rd_data_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    len_next   = len_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                len_next   = len_reg + 1'b1;
                state_next = S_EMIT;
            end
            S_REL_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_REL_EMIT;
            end
            S_REL_EMIT:
            begin
                if (out_free)
                begin
                    clock_next        = u_value;
                    result_valid_next = 1'b1;
                    result_next       = '{action: ACT_REPLY, dest_id: rd_data_reg.id,
                                          stamp: u_value, done_count: done_reg,
                                          last: rel_last};
                    if (rel_last)
                    begin
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_REL_READ;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{action: pend_reg.action, dest_id: pend_reg.dest_id,
                                          stamp: pend_reg.stamp, done_count: done_reg,
                                          last: 1'b1};
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            own_id_reg       <= ID_W'(1);
            proc_cnt_reg     <= ID_W'(2);
            clock_reg        <= '0;
            requested_reg    <= 1'b0;
            own_time_reg     <= '0;
            reply_cnt_reg    <= '0;
            done_reg         <= '0;
            len_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            own_id_reg       <= own_id_next;
            proc_cnt_reg     <= proc_cnt_next;
            clock_reg        <= clock_next;
            requested_reg    <= requested_next;
            own_time_reg     <= own_time_next;
            reply_cnt_reg    <= reply_cnt_next;
            done_reg         <= done_next;
            len_reg          <= len_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(QUEUE_DEPTH))
        else $error("queue length beyond depth");

    a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
        clock_reg >= $past(clock_reg))
        else $error("Lamport clock went backward");

    a_own_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && requested_reg |-> len_reg != '0)
        else $error("requested with empty queue");

    a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.action == ACT_GRANT) |-> result_reg.last)
        else $error("grant not the final beat");

endmodule
